// File: rtl/core/lzsd_pkg.sv
// Shared types and constants of the LZSS stream decoder.
// No dependencies; imported by the decoder core.
package lzsd_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DICT_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_BYTE = 2'd2;

    // Register reset values
    localparam logic [3:0] RST_DICT_BITS = 4'd12;
    localparam logic [3:0] RST_THRESHOLD = 4'd2;
    localparam logic [7:0] RST_FILL_BYTE = 8'd32;

    // Ring pointer, run length and flag widths
    localparam int PTR_W  = 12;
    localparam int LEN_W  = 6;
    localparam int FLAG_W = 16;

    // Flag byte is loaded with a sentinel above it to count eight tokens
    localparam logic [FLAG_W-1:0] FLAG_SENTINEL = 16'hFF00;

    // Masks for the two ring sizes
    localparam logic [PTR_W-1:0] MASK_4K = 12'hFFF;
    localparam logic [PTR_W-1:0] MASK_2K = 12'h7FF;

    // Start pointer N - F before the threshold is taken off
    localparam logic [PTR_W-1:0] WP_BASE_4K = 12'd4080;
    localparam logic [PTR_W-1:0] WP_BASE_2K = 12'd2016;

    // Token parse phase; the unused code behaves like PH_FLAG
    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_MATCH = 2'd2
    } t_phase;

endpackage

// File: rtl/core/lzsd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old content.
module lzsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then register the read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/lzss_stream_decoder_core.sv
// LZSS stream decoder core: one compressed byte in, zero or more bytes out.
// Depends on lzsd_pkg and lzsd_ram.
//
// Decodes an LZSS stream in the classic flag-byte format, one compressed
// byte per input beat. Flag bytes and the first byte of a match produce no
// output; a literal produces one byte; a match produces length bytes copied
// from the history ring. A literal and the final byte of each run are marked by
// o_last_of_run. The ring RAM delivers one copied byte per cycle while the
// output is not stalled, and a byte read in the same cycle as it is written
// is forwarded. After reset, and after every beat with i_stream_start set,
// the block fills the whole ring with the fill byte, one entry a cycle; no
// input beat is taken during the fill (configuration writes still are). The
// output has a one-beat register, so output stall only holds the block once
// a second result is ready. Configuration may be written only while the
// block is idle; a changed fill byte takes effect at the next stream start.
module lzss_stream_decoder_core #(
    parameter int RING_DEPTH = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [lzsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lzsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Compressed byte input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_stream_start,
    // Decompressed byte output
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last_of_run
);

    import lzsd_pkg::*;

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam logic CAN_4K = (RING_DEPTH >= 4096);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(RING_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_COPY
    } t_state;

    // Registers
    t_state              r_state;
    logic [3:0]          r_dict_bits;
    logic [3:0]          r_threshold;
    logic [7:0]          r_fill_byte;
    logic [7:0]          r_clr_fill;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic                r_pend;
    logic [7:0]          r_byte;
    logic [PTR_W-1:0]    r_wp;
    logic [FLAG_W-1:0]   r_flag;
    t_phase              r_phase;
    logic [7:0]          r_held_low;
    logic [PTR_W-1:0]    r_pos;
    logic [LEN_W-1:0]    r_remain;
    logic                r_rd_pend;
    logic                r_fwd;
    logic [7:0]          r_fwd_data;
    logic                r_hold_valid;
    logic [7:0]          r_hold;
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_out_last;

    // Combinational
    logic                eff_4k;
    logic [PTR_W-1:0]    mask;
    logic [PTR_W-1:0]    wp_m;
    logic [PTR_W-1:0]    wp_start;
    logic                in_accept;
    logic                out_free;
    logic [7:0]          rd_val;
    logic                cp_valid;
    logic [7:0]          cp_val;
    logic                cp_commit;
    logic                cp_last;
    logic                lit_commit;
    logic                match_go;
    logic [PTR_W-1:0]    m_pos;
    logic [LEN_W-1:0]    m_len;
    logic                ram_we;
    logic [PTR_W-1:0]    ram_wptr;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [7:0]          ram_wdata;
    logic                rd_issue;
    logic [PTR_W-1:0]    rd_ptr;
    logic [7:0]          ram_rdata;

    // Effective ring size: 4K only for dict_bits of 12 or more and a deep RAM
    assign eff_4k   = CAN_4K && (r_dict_bits >= 4'd12);
    assign mask     = eff_4k ? MASK_4K : MASK_2K;
    assign wp_m     = r_wp & mask;
    assign wp_start = (eff_4k ? WP_BASE_4K : WP_BASE_2K) - PTR_W'(r_threshold);

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // Copy path: forwarded, fresh or held byte
    assign rd_val    = r_fwd ? r_fwd_data : ram_rdata;
    assign cp_valid  = r_rd_pend || r_hold_valid;
    assign cp_val    = r_hold_valid ? r_hold : rd_val;
    assign cp_commit = (r_state == ST_COPY) && cp_valid && out_free;
    assign cp_last   = (r_remain == '0);

    assign lit_commit = (r_state == ST_EXEC) && (r_phase == PH_TOKEN) && r_flag[0] && out_free;
    assign match_go   = (r_state == ST_EXEC) && (r_phase == PH_MATCH);

    // Match token decode
    always_comb begin
        if (eff_4k) begin
            m_pos = {r_byte[7:4], r_held_low};
            m_len = LEN_W'(r_byte[3:0]) + LEN_W'(r_threshold) + LEN_W'(1);
        end else begin
            m_pos = {1'b0, r_byte[7:5], r_held_low};
            m_len = LEN_W'(r_byte[4:0]) + LEN_W'(r_threshold) + LEN_W'(1);
        end
    end

    // Ring write port: clearing pass, literal or copied byte
    always_comb begin
        ram_we    = 1'b0;
        ram_wptr  = wp_m;
        ram_wdata = r_byte;
        ram_waddr = wp_m[ADDR_W-1:0];
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = r_clr_fill;
        end else if (lit_commit) begin
            ram_we = 1'b1;
        end else if (cp_commit) begin
            ram_we    = 1'b1;
            ram_wptr  = r_wp;
            ram_waddr = r_wp[ADDR_W-1:0];
            ram_wdata = cp_val;
        end
    end

    // Ring read port: first byte of a match, then one per committed byte but the last
    always_comb begin
        rd_issue = 1'b0;
        rd_ptr   = r_pos;
        if (match_go) begin
            rd_issue = 1'b1;
            rd_ptr   = m_pos;
        end else if (cp_commit && !cp_last) begin
            rd_issue = 1'b1;
        end
    end

    lzsd_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_ptr[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Sequencer, token state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_dict_bits  <= RST_DICT_BITS;
            r_threshold  <= RST_THRESHOLD;
            r_fill_byte  <= RST_FILL_BYTE;
            r_clr_fill   <= RST_FILL_BYTE;
            r_clr_addr   <= '0;
            r_pend       <= 1'b0;
            r_wp         <= CAN_4K ? (WP_BASE_4K - PTR_W'(RST_THRESHOLD))
                                   : (WP_BASE_2K - PTR_W'(RST_THRESHOLD));
            r_flag       <= '0;
            r_phase      <= PH_FLAG;
            r_held_low   <= '0;
            r_remain     <= '0;
            r_rd_pend    <= 1'b0;
            r_fwd        <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            // Configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DICT_BITS: r_dict_bits <= i_cfg_data[3:0];
                    CFG_THRESHOLD: r_threshold <= i_cfg_data[3:0];
                    CFG_FILL_BYTE: r_fill_byte <= i_cfg_data;
                    default: ;
                endcase
            end

            // Read tracking and forwarding of a same-cycle write
            r_rd_pend  <= rd_issue;
            r_fwd      <= rd_issue && ram_we && (rd_ptr == ram_wptr);
            r_fwd_data <= ram_wdata;

            // Hold a returned byte while the output is blocked
            if (cp_commit) begin
                r_hold_valid <= 1'b0;
            end else if ((r_state == ST_COPY) && r_rd_pend && !out_free) begin
                r_hold_valid <= 1'b1;
                r_hold       <= rd_val;
            end

            // Output register
            if (lit_commit || cp_commit) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= lit_commit ? r_byte : cp_val;
                r_out_last  <= lit_commit || cp_last;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == CLR_LAST) begin
                        r_clr_addr <= '0;
                        r_state    <= r_pend ? ST_EXEC : ST_IDLE;
                        r_pend     <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        r_byte <= i_in_byte;
                        if (i_stream_start) begin
                            r_clr_fill <= r_fill_byte;
                            r_wp       <= wp_start & mask;
                            r_flag     <= '0;
                            r_phase    <= PH_FLAG;
                            r_held_low <= '0;
                            r_pend     <= 1'b1;
                            r_state    <= ST_CLEAR;
                        end else begin
                            r_state <= ST_EXEC;
                        end
                    end
                end
                ST_EXEC: begin
                    r_wp <= wp_m;
                    case (r_phase)
                        PH_TOKEN: begin
                            if (r_flag[0]) begin
                                // Literal: wait for the output register
                                if (out_free) begin
                                    r_wp    <= (wp_m + PTR_W'(1)) & mask;
                                    r_flag  <= r_flag >> 1;
                                    r_phase <= r_flag[9] ? PH_TOKEN : PH_FLAG;
                                    r_state <= ST_IDLE;
                                end
                            end else begin
                                r_held_low <= r_byte;
                                r_phase    <= PH_MATCH;
                                r_state    <= ST_IDLE;
                            end
                        end
                        PH_MATCH: begin
                            // First read goes out now; start the copy
                            r_pos    <= (m_pos + PTR_W'(1)) & mask;
                            r_remain <= m_len - LEN_W'(1);
                            r_state  <= ST_COPY;
                        end
                        default: begin
                            r_flag  <= {8'd0, r_byte} | FLAG_SENTINEL;
                            r_phase <= PH_TOKEN;
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
                ST_COPY: begin
                    if (cp_commit) begin
                        r_wp <= (r_wp + PTR_W'(1)) & mask;
                        if (cp_last) begin
                            r_flag  <= r_flag >> 1;
                            r_phase <= r_flag[9] ? PH_TOKEN : PH_FLAG;
                            r_state <= ST_IDLE;
                        end else begin
                            r_pos    <= (r_pos + PTR_W'(1)) & mask;
                            r_remain <= r_remain - LEN_W'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

endmodule

// File: dv/tb_lzss_stream_decoder_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for lzss_stream_decoder_core: feeds compressed streams and
// checks every decoded beat against a behavioral decoder kept in step with the inputs.
// Depends on lzsd_pkg and the decoder core RTL.
module tb_lzss_stream_decoder_core;
    import lzsd_pkg::*;

    localparam int RING_DEPTH = 4096;
    localparam int SETTLE_CYC = RING_DEPTH + 64;      // ring clearing pass plus slack
    localparam int DRAIN_CYC  = 64;
    localparam int WDOG_LIMIT = 8 * RING_DEPTH + 4000;
    localparam int HOLD_CYC   = 400;
    localparam int IDLE_PCT   = 18;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_beat;

    // DUT ports
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [7:0]            i_in_byte;
    logic                  i_stream_start;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [7:0]            o_out_byte;
    logic                  o_last_of_run;

    // Decoder state mirror
    logic [3:0]        dict_bits_q;
    logic [3:0]        threshold_q;
    logic [7:0]        fill_q;
    logic [7:0]        hist_ring [RING_DEPTH];
    logic [PTR_W-1:0]  wr_ptr;
    logic [FLAG_W-1:0] flag_sr;
    t_phase            phase;
    logic [7:0]        pos_lo;
    t_out_beat         expected_bytes [$];

    int mismatches   = 0;
    int bytes_sent   = 0;
    int idle_cycles  = 0;
    int hold_left    = 0;
    bit hold_req     = 1'b0;
    bit hold_done    = 1'b0;
    bit quiet        = 1'b0;

    lzss_stream_decoder_core #(
        .RING_DEPTH(RING_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .i_stream_start (i_stream_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Ring size in bits after clamping to the supported range
    function automatic int ring_bits();
        int b;
        b = dict_bits_q;
        if (b < 11) b = 11;
        if (b > 12) b = 12;
        if ((1 << b) > RING_DEPTH) b = 11;
        return b;
    endfunction

    // Clear the ring to the fill byte and park the pointer at N - F
    function automatic void restart_stream();
        int b, n, f, k;
        b = ring_bits();
        n = 1 << b;
        f = (1 << (16 - b)) + threshold_q;
        for (k = 0; k < RING_DEPTH; k++) hist_ring[k] = fill_q;
        wr_ptr  = PTR_W'((n - f) & (n - 1));
        flag_sr = '0;
        phase   = PH_FLAG;
        pos_lo  = '0;
    endfunction

    function automatic void store_byte(logic [7:0] v, logic [PTR_W-1:0] mask);
        hist_ring[wr_ptr & mask] = v;
        wr_ptr = (wr_ptr + PTR_W'(1)) & mask;
        expected_bytes.push_back('{data: v, last: 1'b0});
    endfunction

    function automatic void advance_flags();
        flag_sr = flag_sr >> 1;
        if (flag_sr[8]) phase = PH_TOKEN;
        else phase = PH_FLAG;
    endfunction

    // Decode one accepted input beat and queue the bytes it produces
    function automatic void decode_byte(logic [7:0] din, logic start);
        int               b, len, k, first;
        logic [PTR_W-1:0] mask, pos;
        t_out_beat        tail;
        if (start) restart_stream();
        b      = ring_bits();
        mask   = PTR_W'((1 << b) - 1);
        wr_ptr = wr_ptr & mask;
        first  = expected_bytes.size();
        case (phase)
            PH_TOKEN: begin
                if (flag_sr[0]) begin
                    store_byte(din, mask);
                    advance_flags();
                end else begin
                    pos_lo = din;
                    phase  = PH_MATCH;
                end
            end
            PH_MATCH: begin
                if (b == 12) begin
                    pos = {din[7:4], pos_lo};
                    len = din[3:0] + threshold_q + 1;
                end else begin
                    pos = {1'b0, din[7:5], pos_lo};
                    len = din[4:0] + threshold_q + 1;
                end
                // copy one byte at a time so overlapping runs repeat fresh bytes
                for (k = 0; k < len; k++) begin
                    store_byte(hist_ring[pos], mask);
                    pos = (pos + PTR_W'(1)) & mask;
                end
                advance_flags();
            end
            default: begin
                flag_sr = FLAG_SENTINEL | FLAG_W'(din);
                phase   = PH_TOKEN;
            end
        endcase
        // mark the final byte of this beat's run
        if (expected_bytes.size() > first) begin
            tail = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
        end
    endfunction

    function automatic void note_mismatch(string what, t_out_beat want);
        if (mismatches < 10)
            $display("%s: expected byte %02h last %0b, got byte %02h last %0b",
                     what, want.data, want.last, o_out_byte, o_last_of_run);
        mismatches++;
    endfunction

    // Compare each output beat with the oldest expected byte
    always @(posedge i_clk) begin : check_out
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                note_mismatch("unexpected beat", '0);
            end else begin
                want = expected_bytes.pop_front();
                if (want.data !== o_out_byte || want.last !== o_last_of_run)
                    note_mismatch("data mismatch", want);
            end
        end
    end

    // Receiver: random stall, or one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYC;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Offer one input beat, with an optional random gap, and wait for accept
    task automatic send_byte(input logic [7:0] din, input logic start);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_in_byte      <= din;
        i_stream_start <= start;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        decode_byte(din, start);
        bytes_sent++;
    endtask

    // Drop valid, wait for every expected byte, then let the block go quiet
    task automatic settle(input int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (cycles) @(posedge i_clk);
    endtask

    // Write all three registers; only called while the block is idle
    task automatic set_config(input logic [3:0] dbits, input logic [3:0] thr,
                              input logic [7:0] fill);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DICT_BITS;
        i_cfg_data  <= CFG_DATA_W'(dbits);
        @(negedge i_clk);
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_data  <= CFG_DATA_W'(thr);
        @(negedge i_clk);
        i_cfg_index <= CFG_FILL_BYTE;
        i_cfg_data  <= fill;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        dict_bits_q = dbits;
        threshold_q = thr;
        fill_q      = fill;
    endtask

    // One flag byte and its eight tokens with random content; a broken group
    // stops early, possibly between the two bytes of a match
    task automatic send_group(input logic start, input bit broken);
        logic [7:0] flags;
        int         stop_at, sent, k;
        flags   = 8'($urandom);
        stop_at = broken ? $urandom_range(0, 14) : 16;
        sent    = 0;
        send_byte(flags, start);
        for (k = 0; k < 8 && sent < stop_at; k++) begin
            send_byte(8'($urandom), 1'b0);
            sent++;
            if (!flags[k] && sent < stop_at) begin
                send_byte(8'($urandom), 1'b0);
                sent++;
            end
        end
    endtask

    // Literals at the byte extremes, overlapping and wrapping matches, a cut-off token
    task automatic test_directed_tokens();
        logic [7:0] lits [8] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};
        int k;
        send_byte(8'hFF, 1'b0);
        for (k = 0; k < 8; k++) send_byte(lits[k], 1'b0);
        send_byte(8'h00, 1'b0);
        // copy from the byte just written: run of repeats
        send_byte(8'hF5, 1'b0);
        send_byte(8'hF0, 1'b0);
        // top position, longest length, wraps the ring
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        // position zero, shortest length
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        // match cut off by a new stream; the restart byte is a flag byte
        send_byte(8'h12, 1'b0);
        send_byte(8'hFE, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h5F, 1'b0);
        send_byte(8'h3C, 1'b0);
    endtask

    // Ring size and threshold at their extremes, each with a fresh stream and its own fill byte
    task automatic test_config_extremes();
        logic [3:0] dbits_list [4] = '{4'd11, 4'd11, 4'd12, 4'd12};
        logic [3:0] thr_list   [4] = '{4'd0, 4'd15, 4'd15, 4'd0};
        logic [7:0] fill_list  [4] = '{8'h00, 8'hFF, 8'h5A, 8'hC3};
        int k;
        for (k = 0; k < 4; k++) begin
            settle(SETTLE_CYC);
            set_config(dbits_list[k], thr_list[k], fill_list[k]);
            send_group(1'b1, 1'b0);
        end
        // threshold change in the middle of a stream
        settle(SETTLE_CYC);
        set_config(4'd12, 4'd7, 8'hC3);
        send_group(1'b0, 1'b0);
        settle(SETTLE_CYC);
        set_config(RST_DICT_BITS, RST_THRESHOLD, RST_FILL_BYTE);
    endtask

    // Mostly well-formed groups; some restarts, broken groups and stray bytes
    task automatic test_random_streams();
        int goal, r;
        goal = bytes_sent + 20;
        send_group(1'b1, 1'b0);
        while (bytes_sent < goal) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                send_group(1'b1, 1'b0);
            end else if (r < 14) begin
                send_group(1'b0, 1'b1);
                send_group(1'b1, 1'b0);
            end else if (r < 20) begin
                send_byte(8'($urandom), $urandom_range(0, 7) == 0);
            end else begin
                send_group(1'b0, 1'b0);
            end
        end
    endtask

    // Full rate on both sides, then a long output hold-off that backs up the input
    task automatic test_output_hold();
        quiet = 1'b1;
        send_group(1'b0, 1'b0);
        send_group(1'b0, 1'b0);
        hold_req = 1'b1;
        send_group(1'b0, 1'b0);
        quiet = 1'b0;
        send_group(1'b0, 1'b0);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_DICT_BITS;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_in_byte      = '0;
        i_stream_start = 1'b0;
        dict_bits_q    = RST_DICT_BITS;
        threshold_q    = RST_THRESHOLD;
        fill_q         = RST_FILL_BYTE;
        restart_stream();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_tokens();
        test_config_extremes();
        test_random_streams();
        test_output_hold();
        settle(DRAIN_CYC);

        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/lzsd_pkg.sv
rtl/core/lzsd_ram.sv
rtl/core/lzss_stream_decoder_core.sv
dv/tb_lzss_stream_decoder_core.sv
